// ===== rtl/core/yrgb_pkg.sv =====
// Package: types and constants shared by the YUYV to RGB565 converter.
`timescale 1ns / 1ps
`default_nettype none

package yrgb_pkg;

  localparam int BYTE_W = 8;
  localparam int PIX_W  = 16;
  localparam int GAIN_W = 9;
  localparam int COEF_W = 19;
  localparam int DIFF_W = 9;
  localparam int PROD_W = 27;
  localparam int SUM_W  = 28;

  localparam logic signed [COEF_W-1:0] COEF_Y       = 19'sd76309;
  localparam logic signed [COEF_W-1:0] COEF_U_BLUE  = 19'sd132201;
  localparam logic signed [COEF_W-1:0] COEF_U_GREEN = -19'sd25674;
  localparam logic signed [COEF_W-1:0] COEF_V_GREEN = -19'sd53278;
  localparam logic signed [COEF_W-1:0] COEF_V_RED   = 19'sd104597;

  localparam logic signed [DIFF_W-1:0] LUMA_OFFSET   = 9'sd16;
  localparam logic signed [DIFF_W-1:0] CHROMA_OFFSET = 9'sd128;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 9'd220;
  localparam logic [GAIN_W-1:0] GAIN_MAX   = 9'd256;

  typedef struct packed {
    logic [BYTE_W-1:0] luma_first;
    logic [BYTE_W-1:0] chroma_blue;
    logic [BYTE_W-1:0] luma_second;
    logic [BYTE_W-1:0] chroma_red;
    logic              last_in_frame;
  } yrgb_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_first;
    logic [PIX_W-1:0] pixel_second;
    logic             frame_end;
  } yrgb_out_t;

  // Coefficient products of one pair.
  typedef struct packed {
    logic signed [PROD_W-1:0] luma_first;
    logic signed [PROD_W-1:0] luma_second;
    logic signed [PROD_W-1:0] u_blue;
    logic signed [PROD_W-1:0] u_green;
    logic signed [PROD_W-1:0] v_green;
    logic signed [PROD_W-1:0] v_red;
    logic                     last;
  } yrgb_prod_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
  } yrgb_rgb_t;

  // Clamped channels of one pair.
  typedef struct packed {
    yrgb_rgb_t first;
    yrgb_rgb_t second;
    logic      last;
  } yrgb_chan_t;

endpackage

`default_nettype wire

// ===== rtl/core/yrgb_mult_stage.sv =====
// Stage 1: offset removal and coefficient multiplies.
`timescale 1ns / 1ps
`default_nettype none

module yrgb_mult_stage
  import yrgb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire yrgb_in_t   in_data,
  output logic            out_valid,
  output yrgb_prod_t      out_data
);

  logic signed [DIFF_W-1:0] y0_d, y1_d, u_d, v_d;
  yrgb_prod_t prod_nxt, prod_r;
  logic       valid_r;

  always_comb begin
    y0_d = $signed({1'b0, in_data.luma_first})  - LUMA_OFFSET;
    y1_d = $signed({1'b0, in_data.luma_second}) - LUMA_OFFSET;
    u_d  = $signed({1'b0, in_data.chroma_blue}) - CHROMA_OFFSET;
    v_d  = $signed({1'b0, in_data.chroma_red})  - CHROMA_OFFSET;
    prod_nxt.luma_first  = PROD_W'(y0_d * COEF_Y);
    prod_nxt.luma_second = PROD_W'(y1_d * COEF_Y);
    prod_nxt.u_blue      = PROD_W'(u_d * COEF_U_BLUE);
    prod_nxt.u_green     = PROD_W'(u_d * COEF_U_GREEN);
    prod_nxt.v_green     = PROD_W'(v_d * COEF_V_GREEN);
    prod_nxt.v_red       = PROD_W'(v_d * COEF_V_RED);
    prod_nxt.last        = in_data.last_in_frame;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      prod_r <= prod_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = prod_r;

endmodule

`default_nettype wire

// ===== rtl/core/yrgb_sum_clamp.sv =====
// Stage 2: channel sums, floor shift by 16 and clamp to 0..255.
`timescale 1ns / 1ps
`default_nettype none

module yrgb_sum_clamp
  import yrgb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire yrgb_prod_t in_data,
  output logic            out_valid,
  output yrgb_chan_t      out_data
);

  function automatic logic [BYTE_W-1:0] clamp_byte(input logic signed [SUM_W-1:0] sum);
    logic [BYTE_W-1:0] res;
    if (sum[SUM_W-1]) begin
      res = '0;
    end else if (|sum[SUM_W-2:24]) begin
      res = '1;
    end else begin
      res = sum[23:16];
    end
    return res;
  endfunction

  logic signed [SUM_W-1:0] ext_y0, ext_y1, ext_ub, ext_ug, ext_vg, ext_vr;
  yrgb_chan_t chan_nxt, chan_r;
  logic       valid_r;

  always_comb begin
    ext_y0 = SUM_W'(in_data.luma_first);
    ext_y1 = SUM_W'(in_data.luma_second);
    ext_ub = SUM_W'(in_data.u_blue);
    ext_ug = SUM_W'(in_data.u_green);
    ext_vg = SUM_W'(in_data.v_green);
    ext_vr = SUM_W'(in_data.v_red);
    chan_nxt.first.red    = clamp_byte(ext_y0 + ext_vr);
    chan_nxt.first.green  = clamp_byte(ext_y0 + ext_ug + ext_vg);
    chan_nxt.first.blue   = clamp_byte(ext_y0 + ext_ub);
    chan_nxt.second.red   = clamp_byte(ext_y1 + ext_vr);
    chan_nxt.second.green = clamp_byte(ext_y1 + ext_ug + ext_vg);
    chan_nxt.second.blue  = clamp_byte(ext_y1 + ext_ub);
    chan_nxt.last         = in_data.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      chan_r <= chan_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = chan_r;

endmodule

`default_nettype wire

// ===== rtl/core/yrgb_gain_pack.sv =====
// Stage 3: gain scaling and RGB565 packing into the output register.
`timescale 1ns / 1ps
`default_nettype none

module yrgb_gain_pack
  import yrgb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire yrgb_chan_t        in_data,
  input  wire logic [GAIN_W-1:0] gain,
  output logic                   out_valid,
  output yrgb_out_t              out_data
);

  function automatic logic [BYTE_W-1:0] scale(input logic [BYTE_W-1:0] c,
                                              input logic [GAIN_W-1:0] g);
    logic [BYTE_W+GAIN_W-1:0] p;
    p = {{GAIN_W{1'b0}}, c} * {{BYTE_W{1'b0}}, g};
    // g never exceeds 256, so the scaled value fits in a byte
    return p[2*BYTE_W-1:BYTE_W];
  endfunction

  function automatic logic [PIX_W-1:0] pack(input yrgb_rgb_t px, input logic [GAIN_W-1:0] g);
    logic [BYTE_W-1:0] r, gr, b;
    r  = scale(px.red, g);
    gr = scale(px.green, g);
    b  = scale(px.blue, g);
    return {r[7:3], gr[7:2], b[7:3]};
  endfunction

  logic [GAIN_W-1:0] gain_eff;
  yrgb_out_t         out_nxt, out_r;
  logic              valid_r;

  always_comb begin
    gain_eff             = (gain > GAIN_MAX) ? GAIN_MAX : gain;
    out_nxt.pixel_first  = pack(in_data.first, gain_eff);
    out_nxt.pixel_second = pack(in_data.second, gain_eff);
    out_nxt.frame_end    = in_data.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== rtl/core/yuyv_to_rgb565_converter.sv =====
// Top level: three-stage YUYV 4:2:2 to RGB565 pair converter.
`timescale 1ns / 1ps
`default_nettype none

// Converts one YUYV group (Y0, U, Y1, V) per item into two RGB565 pixels
// sharing the chroma, using BT.601 studio-range Q16 coefficients, a clamp
// to 0..255 and a gain of output_gain/256 (values above 256 act as 256).
// The block takes one item every cycle: busy is always low. Each item
// passes through the register stages and leaves on out_data, marked by
// a one-cycle out_valid strobe; the receiver must take it in that cycle.
// The register stages are: coefficient multiplies, channel sum and clamp,
// gain multiply and pack. Write the gain through cfg_wr_en and cfg_wr_data
// only while no item is in flight; the new gain applies to items accepted
// afterwards.
module yuyv_to_rgb565_converter
  import yrgb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input item channel
  input  wire logic              start,
  output logic                   busy,
  input  wire yrgb_in_t          in_data,
  // result channel
  output logic                   out_valid,
  output yrgb_out_t              out_data,
  // configuration: output_gain
  input  wire logic              cfg_wr_en,
  input  wire logic [GAIN_W-1:0] cfg_wr_data
);

  logic [GAIN_W-1:0] gain_r;
  logic              in_take;
  logic              s1_valid, s2_valid;
  yrgb_prod_t        s1_data;
  yrgb_chan_t        s2_data;

  // Never stall: every stage advances each cycle.
  assign busy    = 1'b0;
  assign in_take = start & ~busy;

  // Hold the gain register; reset to the default gain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
    end else if (cfg_wr_en) begin
      gain_r <= cfg_wr_data;
    end
  end

  yrgb_mult_stage u_mult (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_take),
    .in_data   (in_data),
    .out_valid (s1_valid),
    .out_data  (s1_data)
  );

  yrgb_sum_clamp u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s1_valid),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_data  (s2_data)
  );

  yrgb_gain_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid),
    .in_data   (s2_data),
    .gain      (gain_r),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== tb/tb_yuyv_to_rgb565_converter.sv =====
// Self-checking testbench for the YUYV to RGB565 pair converter.
`timescale 1ns / 1ps

module tb_yuyv_to_rgb565_converter;
  import yrgb_pkg::*;

  // Clocking and run bounds.
  localparam time CLK_HALF     = 4ns;
  localparam int  RESET_CYCLES = 7;
  localparam int  PIPE_LATENCY = 3;       // accept edge to result strobe
  localparam int  CYCLE_LIMIT  = 400000;  // far above the slowest legal run
  localparam int  RAND_PHASES  = 8;
  localparam int  RAND_ITEMS   = 136;     // per gain setting

  // Q16 conversion weights, kept separate from the design's own constants.
  localparam int W_LUMA    = 76309;
  localparam int W_U_BLUE  = 132201;
  localparam int W_U_GREEN = -25674;
  localparam int W_V_GREEN = -53278;
  localparam int W_V_RED   = 104597;
  localparam int GAIN_CAP  = 256;

  // One row of the directed table: either a typed-in result or, when
  // known is clear, a result taken from the pixel predictor.
  typedef struct {
    yrgb_in_t  item;
    bit        known;
    yrgb_out_t result;
  } dir_row_t;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  yrgb_in_t         in_data;
  logic             out_valid;
  yrgb_out_t        out_data;
  logic             cfg_wr_en;
  logic [GAIN_W-1:0] cfg_wr_data;

  // Gain the block should be using right now, tracked on every write.
  logic [GAIN_W-1:0] gain_now;
  yrgb_out_t         expected_pairs[$];
  dir_row_t          dir_rows[$];
  int                err_count;
  int                cycle_count;

  yuyv_to_rgb565_converter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  // Floor-shift one channel sum down to 8 bits, clamp, then apply the gain.
  // A negative sum floors to a negative value, so it clamps to zero.
  function automatic int scaled_channel(input int sum, input int gain);
    int level;
    level = (sum < 0) ? 0 : (sum >>> 16);
    if (level > 255) level = 255;
    return (level * gain) >>> 8;
  endfunction

  // Convert one luma byte with the shared chroma into an RGB565 word.
  function automatic logic [PIX_W-1:0] rgb565_pixel(input logic [7:0] luma,
                                                    input logic [7:0] cb,
                                                    input logic [7:0] cr,
                                                    input logic [GAIN_W-1:0] gain);
    int y_term;
    int u_diff;
    int v_diff;
    int g_eff;
    int red;
    int green;
    int blue;
    logic [7:0] r8;
    logic [7:0] g8;
    logic [7:0] b8;
    y_term = W_LUMA * (int'(luma) - 16);
    u_diff = int'(cb) - 128;
    v_diff = int'(cr) - 128;
    // Gains past unity saturate at unity.
    g_eff  = (int'(gain) > GAIN_CAP) ? GAIN_CAP : int'(gain);
    red    = scaled_channel(y_term + W_V_RED * v_diff, g_eff);
    green  = scaled_channel(y_term + W_U_GREEN * u_diff + W_V_GREEN * v_diff, g_eff);
    blue   = scaled_channel(y_term + W_U_BLUE * u_diff, g_eff);
    r8 = red[7:0];
    g8 = green[7:0];
    b8 = blue[7:0];
    return {r8[7:3], g8[7:2], b8[7:3]};
  endfunction

  function automatic yrgb_out_t pair_of(input yrgb_in_t item,
                                        input logic [GAIN_W-1:0] gain);
    yrgb_out_t res;
    res.pixel_first  = rgb565_pixel(item.luma_first,  item.chroma_blue, item.chroma_red, gain);
    res.pixel_second = rgb565_pixel(item.luma_second, item.chroma_blue, item.chroma_red, gain);
    res.frame_end    = item.last_in_frame;
    return res;
  endfunction

  function automatic yrgb_in_t make_item(input logic [7:0] y0, input logic [7:0] u,
                                         input logic [7:0] y1, input logic [7:0] v,
                                         input logic last);
    yrgb_in_t item;
    item.luma_first    = y0;
    item.chroma_blue   = u;
    item.luma_second   = y1;
    item.chroma_red    = v;
    item.last_in_frame = last;
    return item;
  endfunction

  // Bytes lean toward the range edges and the zero points of the transform.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd16;
      3:       return 8'd128;
      4:       return 8'd235;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic yrgb_in_t random_item();
    return make_item(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                     ($urandom_range(0, 7) == 0));
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic add_row(input yrgb_in_t item, input bit known, input yrgb_out_t result);
    dir_row_t row;
    row.item   = item;
    row.known  = known;
    row.result = result;
    dir_rows.push_back(row);
  endtask

  task automatic report_mismatch(input string field, input logic [PIX_W-1:0] got,
                                 input logic [PIX_W-1:0] want);
    $display("[%0t] %s differs: got %h, want %h", $time, field, got, want);
    err_count++;
  endtask

  // Present one item and hold it until the block takes it. Start stays high
  // on return, so a following item goes out without a bubble.
  task automatic drive_item(input yrgb_in_t item, input bit known, input yrgb_out_t result);
    @(negedge clk);
    start   <= 1'b1;
    in_data <= item;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    expected_pairs.push_back(known ? result : pair_of(item, gain_now));
  endtask

  // Drop start, with junk on the data bus to show it is ignored; n sets the gap.
  task automatic idle_cycles(input int n);
    if (n > 0) begin
      @(negedge clk);
      start   <= 1'b0;
      in_data <= random_item();
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Hold off until every pending pair has come back, then let the pipe settle.
  task automatic drain_pipe();
    @(negedge clk);
    start <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 1) @(posedge clk);
  endtask

  // The gain may only change with nothing in flight.
  task automatic write_gain(input logic [GAIN_W-1:0] value);
    drain_pipe();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= GAIN_W'($urandom);
    gain_now     = value;
  endtask

  // Check each strobed pair against the oldest pending expectation.
  always @(posedge clk) begin
    yrgb_out_t want;
    if (rst_n && out_valid) begin
      if (expected_pairs.size() == 0) begin
        report_mismatch("unexpected pair", out_data.pixel_first, '0);
      end else begin
        want = expected_pairs.pop_front();
        if (out_data.pixel_first !== want.pixel_first)
          report_mismatch("pixel_first", out_data.pixel_first, want.pixel_first);
        if (out_data.pixel_second !== want.pixel_second)
          report_mismatch("pixel_second", out_data.pixel_second, want.pixel_second);
        if (out_data.frame_end !== want.frame_end)
          report_mismatch("frame_end", PIX_W'(out_data.frame_end), PIX_W'(want.frame_end));
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    yrgb_out_t   blank;
    yrgb_out_t   black;
    yrgb_out_t   white;
    yrgb_out_t   black_last;
    yrgb_out_t   split;
    logic [GAIN_W-1:0] gain_plan[RAND_PHASES];
    bit          no_gaps;

    // Drive every input to a known value from time zero.
    start       = 1'b0;
    in_data     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    rst_n       = 1'b0;
    err_count   = 0;
    cycle_count = 0;
    gain_now    = GAIN_RESET;

    // Results that follow from the formulas at a glance, at the reset gain:
    // neutral chroma at black gives zero, saturated white clamps to 255 and
    // scales to 219, which packs to 0xDEDB.
    blank      = '0;
    black      = '{pixel_first: 16'h0000, pixel_second: 16'h0000, frame_end: 1'b0};
    white      = '{pixel_first: 16'hDEDB, pixel_second: 16'hDEDB, frame_end: 1'b0};
    black_last = '{pixel_first: 16'h0000, pixel_second: 16'h0000, frame_end: 1'b1};
    split      = '{pixel_first: 16'h0000, pixel_second: 16'hDEDB, frame_end: 1'b0};

    add_row(make_item(8'd16,  8'd128, 8'd16,  8'd128, 1'b0), 1'b1, black);
    add_row(make_item(8'd255, 8'd128, 8'd255, 8'd128, 1'b0), 1'b1, white);
    // Luma below black level drives every sum negative.
    add_row(make_item(8'd0,   8'd128, 8'd0,   8'd128, 1'b1), 1'b1, black_last);
    add_row(make_item(8'd16,  8'd128, 8'd255, 8'd128, 1'b0), 1'b1, split);
    // Field extremes and chroma corners go to the predictor.
    add_row(make_item(8'd255, 8'd255, 8'd255, 8'd255, 1'b1), 1'b0, blank);
    add_row(make_item(8'd0,   8'd0,   8'd0,   8'd0,   1'b0), 1'b0, blank);
    add_row(make_item(8'd255, 8'd0,   8'd0,   8'd255, 1'b0), 1'b0, blank);
    add_row(make_item(8'd0,   8'd255, 8'd255, 8'd0,   1'b1), 1'b0, blank);
    add_row(make_item(8'd255, 8'd255, 8'd0,   8'd0,   1'b0), 1'b0, blank);
    add_row(make_item(8'd128, 8'd0,   8'd128, 8'd255, 1'b1), 1'b0, blank);
    add_row(make_item(8'd16,  8'd255, 8'd235, 8'd255, 1'b0), 1'b0, blank);
    add_row(make_item(8'd235, 8'd0,   8'd16,  8'd0,   1'b0), 1'b0, blank);
    add_row(make_item(8'd81,  8'd90,  8'd145, 8'd240, 1'b0), 1'b0, blank);
    add_row(make_item(8'hAA,  8'h55,  8'h55,  8'hAA,  1'b0), 1'b0, blank);
    add_row(make_item(8'h55,  8'hAA,  8'hAA,  8'h55,  1'b1), 1'b0, blank);

    // Gain settings: unity, zero, all ones (saturates to unity), one, just past
    // unity, just below unity, half and one picked at random.
    gain_plan[0] = GAIN_MAX;
    gain_plan[1] = '0;
    gain_plan[2] = '1;
    gain_plan[3] = GAIN_W'(1);
    gain_plan[4] = GAIN_W'(257);
    gain_plan[5] = GAIN_W'(255);
    gain_plan[6] = GAIN_W'(128);
    gain_plan[7] = GAIN_W'($urandom_range(0, 511));

    // Hold reset, then release it on a falling edge.
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table at the reset gain.
    foreach (dir_rows[i]) begin
      drive_item(dir_rows[i].item, dir_rows[i].known, dir_rows[i].result);
      idle_cycles(gap_len());
    end

    // Random traffic, one gain setting per phase. Some phases run without
    // gaps at all so the pipe stays full; now and then stop and drain.
    for (int p = 0; p < RAND_PHASES; p++) begin
      write_gain(gain_plan[p]);
      no_gaps = ($urandom_range(0, 2) == 0);
      for (int n = 0; n < RAND_ITEMS; n++) begin
        drive_item(random_item(), 1'b0, blank);
        if ($urandom_range(0, 99) == 0) drain_pipe();
        else if (!no_gaps) idle_cycles(gap_len());
      end
    end

    // Wait out the tail of the pipe and report.
    drain_pipe();
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
